// File: rtl/ppf_pkg.sv
// Shared constants, types and helpers for the primed playback FIFO.
`timescale 1ns / 1ps

package ppf_pkg;

    localparam int RING_FRAMES  = 1024;
    localparam int CH_SLOTS     = 8;
    localparam int FRAME_W      = $clog2(RING_FRAMES);
    localparam int CH_W         = $clog2(CH_SLOTS) > 0 ? $clog2(CH_SLOTS) : 1;
    localparam int ADDR_W       = FRAME_W + CH_W;
    localparam int FILL_W       = FRAME_W + 1;

    typedef enum logic [2:0] {
        CMD_SUBMIT = 3'd0,
        CMD_RENDER = 3'd1,
        CMD_START  = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_FAULT  = 3'd5
    } t_cmd;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PRIMED  = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_PAUSED  = 3'd3;
    localparam logic [2:0] ST_FAULTED = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_READY = 2'd1;
    localparam logic [1:0] STS_INVALID   = 2'd2;

    localparam logic [0:0] REG_CHANNELS  = 1'd0;
    localparam logic [0:0] REG_THRESHOLD = 1'd1;

    // One result word as it leaves the control unit.
    typedef struct packed {
        logic [1:0]        status_code;
        logic              sample_accepted;
        logic              use_ring;
        logic              last_of_run;
        logic [2:0]        play_state;
        logic [10:0]       frames_held;
        logic [31:0]       underrun_total;
    } t_res;

    function automatic logic [31:0] sanitize(input logic [31:0] b);
        logic [31:0] r;
        if (b[30:23] == 8'hFF) begin
            r = 32'd0;
        end else if (b[30:0] > 31'h3F80_0000) begin
            r = {b[31], 31'h3F80_0000};
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

// File: rtl/ppf_ring.sv
// Sample ring memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ppf_ring (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ppf_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [31:0]                 i_wdata,
    input  logic                        i_re,
    input  logic [ppf_pkg::ADDR_W-1:0]  i_raddr,
    output logic [31:0]                 o_rdata
);

    logic [31:0] r_mem [0:(1 << ppf_pkg::ADDR_W)-1];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/primed_playback_fifo.sv
// Top level: command decode, playback state machine, ring and output stage.
//
//  channel | direction | handshake                  | payload
//  in      | in        | i_in_valid / o_in_stall    | i_cmd, i_sample_bits, i_call_start
//  out     | out       | o_out_valid / i_out_stall  | o_status_code .. o_underrun_total
//  cfg     | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A submit or control word gives one result. A render word issues one result
// per channel, one ring read per cycle while the output queue has room, and
// stalls the input until its last channel has issued; the single read port of
// the ring is why. A result passes from the registered ring read into a
// two-entry output queue before it shows at the output; input keeps flowing
// while one result waits and stalls once the queue and the result in flight
// would fill it. Reset returns all control state to its defaults; ring
// contents stay undefined until written.
`timescale 1ns / 1ps

module primed_playback_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_sample_bits,
    input  logic        i_call_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status_code,
    output logic        o_sample_accepted,
    output logic [31:0] o_out_sample,
    output logic        o_last_of_run,
    output logic [2:0]  o_play_state,
    output logic [10:0] o_held_frames,
    output logic [31:0] o_underrun_total
);

    localparam int FW = ppf_pkg::FRAME_W;
    localparam int CW = ppf_pkg::CH_W;
    localparam int LW = ppf_pkg::FILL_W;

    // configuration
    logic [5:0]  r_channels;
    logic [10:0] r_threshold;

    // engine state
    logic [2:0]    r_state, n_state;
    logic [FW-1:0] r_rd_idx, n_rd_idx, r_wr_idx, n_wr_idx;
    logic [LW-1:0] r_fill, n_fill;
    logic [5:0]    r_pos, n_pos;
    logic          r_drop, n_drop;
    logic [31:0]   r_under, n_under;
    logic          r_call_under, n_call_under;

    // render sequencer
    logic          r_rend;          // emitting a render frame
    logic [5:0]    r_rc;            // channel being emitted
    logic          r_have;
    logic [FW-1:0] r_rbase;

    // pipeline stage after ring read
    logic                 r_p_valid;
    ppf_pkg::t_res        r_p_res;

    // output queue, two entries
    logic [1:0]           r_q_cnt;
    ppf_pkg::t_res        r_q_res [0:1];
    logic [31:0]          r_q_smp [0:1];

    logic [5:0] w_ch;
    always_comb begin
        if (r_channels == 6'd0) begin
            w_ch = 6'd1;
        end else if (r_channels > 6'(ppf_pkg::CH_SLOTS)) begin
            w_ch = 6'(ppf_pkg::CH_SLOTS);
        end else begin
            w_ch = r_channels;
        end
    end

    // Issue is allowed only when the queue can take the result in flight.
    logic w_room;
    logic w_issue;
    logic w_acc;
    logic w_out_take;
    logic w_slot0;
    assign w_out_take = (r_q_cnt != 2'd0) && !i_out_stall;
    assign w_room = ({1'b0, r_q_cnt} + {2'b0, r_p_valid}) < 3'd2
                    || (w_out_take && ({1'b0, r_q_cnt} + {2'b0, r_p_valid}) < 3'd3);
    assign o_in_stall = r_rend || !w_room;
    assign w_acc = i_in_valid && !o_in_stall;
    assign w_issue = w_acc || (r_rend && w_room);
    // the incoming result lands at the head when the queue empties this cycle
    assign w_slot0 = ((w_out_take ? r_q_cnt - 2'd1 : r_q_cnt) == 2'd0);

    // ring access
    logic          w_we, w_re;
    logic [ppf_pkg::ADDR_W-1:0] w_waddr, w_raddr;
    logic [31:0]   w_rdata;
    logic [5:0]    w_rc_cur;
    logic          w_have_cur;
    logic [FW-1:0] w_base_cur;

    ppf_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_sample_bits),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // command decode; render frames follow the state after their first word
    ppf_pkg::t_res w_res;
    logic          w_start_rend;
    always_comb begin
        n_state      = r_state;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_fill       = r_fill;
        n_pos        = r_pos;
        n_drop       = r_drop;
        n_under      = r_under;
        n_call_under = r_call_under;
        w_we         = 1'b0;
        w_waddr      = {r_wr_idx, r_pos[CW-1:0]};
        w_start_rend = 1'b0;
        w_have_cur   = r_have;
        w_base_cur   = r_rbase;
        w_rc_cur     = r_rc;
        w_res        = '0;
        w_res.last_of_run = 1'b1;
        if (r_rend) begin
            w_res.use_ring    = r_have;
            w_res.last_of_run = (r_rc + 6'd1 == w_ch);
        end else if (w_acc) begin
            unique case (i_cmd)
                ppf_pkg::CMD_SUBMIT: begin
                    if (r_state == ppf_pkg::ST_FAULTED) begin
                        w_res.status_code = ppf_pkg::STS_INVALID;
                    end else begin
                        if (r_pos == 6'd0) begin
                            n_drop = r_fill >= LW'(ppf_pkg::RING_FRAMES);
                        end
                        if (!n_drop) begin
                            w_we = 1'b1;
                            w_res.sample_accepted = 1'b1;
                        end
                        if (r_pos + 6'd1 >= w_ch) begin
                            if (!n_drop) begin
                                n_wr_idx = r_wr_idx + FW'(1);
                                n_fill   = r_fill + LW'(1);
                            end
                            n_pos  = 6'd0;
                            n_drop = 1'b0;
                        end else begin
                            n_pos = r_pos + 6'd1;
                        end
                        if (r_state == ppf_pkg::ST_IDLE || r_state == ppf_pkg::ST_PRIMED) begin
                            n_state = ({{(11-LW+1){1'b0}}, n_fill} >= {1'b0, r_threshold})
                                      ? ppf_pkg::ST_PRIMED : ppf_pkg::ST_IDLE;
                        end
                    end
                end
                ppf_pkg::CMD_RENDER: begin
                    w_start_rend = 1'b1;
                    w_have_cur   = 1'b0;
                    w_base_cur   = r_rd_idx;
                    w_rc_cur     = 6'd0;
                    if (i_call_start) begin
                        n_call_under = 1'b0;
                    end
                    if (r_state == ppf_pkg::ST_RUNNING) begin
                        if (r_fill != '0) begin
                            w_have_cur = 1'b1;
                            n_rd_idx   = r_rd_idx + FW'(1);
                            n_fill     = r_fill - LW'(1);
                        end else if (!n_call_under) begin
                            n_call_under = 1'b1;
                            if (r_under != '1) begin
                                n_under = r_under + 32'd1;
                            end
                        end
                    end
                    w_res.use_ring    = w_have_cur;
                    w_res.last_of_run = (w_ch == 6'd1);
                end
                ppf_pkg::CMD_START: begin
                    if (r_state == ppf_pkg::ST_PAUSED || r_state == ppf_pkg::ST_PRIMED) begin
                        n_state = ppf_pkg::ST_RUNNING;
                    end else if (r_state != ppf_pkg::ST_RUNNING) begin
                        w_res.status_code = ppf_pkg::STS_NOT_READY;
                    end
                end
                ppf_pkg::CMD_PAUSE: begin
                    if (r_state == ppf_pkg::ST_RUNNING) begin
                        n_state = ppf_pkg::ST_PAUSED;
                    end else if (r_state != ppf_pkg::ST_PAUSED) begin
                        w_res.status_code = ppf_pkg::STS_INVALID;
                    end
                end
                ppf_pkg::CMD_STOP: begin
                    n_rd_idx     = '0;
                    n_wr_idx     = '0;
                    n_fill       = '0;
                    n_pos        = 6'd0;
                    n_drop       = 1'b0;
                    n_under      = 32'd0;
                    n_call_under = 1'b0;
                    n_state      = (r_threshold == 11'd0) ? ppf_pkg::ST_PRIMED
                                                          : ppf_pkg::ST_IDLE;
                end
                ppf_pkg::CMD_FAULT: begin
                    n_state = ppf_pkg::ST_FAULTED;
                end
                default: begin
                    w_res.status_code = ppf_pkg::STS_INVALID;
                end
            endcase
        end
        w_res.play_state      = n_state;
        w_res.frames_held     = 11'(n_fill);
        w_res.underrun_total  = n_under;
        w_re    = w_issue && w_res.use_ring;
        w_raddr = {w_base_cur, w_rc_cur[CW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels   <= 6'd2;
            r_threshold  <= 11'd0;
            r_state      <= ppf_pkg::ST_PRIMED;
            r_rd_idx     <= '0;
            r_wr_idx     <= '0;
            r_fill       <= '0;
            r_pos        <= 6'd0;
            r_drop       <= 1'b0;
            r_under      <= 32'd0;
            r_call_under <= 1'b0;
            r_rend       <= 1'b0;
            r_rc         <= 6'd0;
            r_have       <= 1'b0;
            r_rbase      <= '0;
            r_p_valid    <= 1'b0;
            r_q_cnt      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ppf_pkg::REG_CHANNELS:  r_channels  <= i_cfg_data[5:0];
                    ppf_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_state      <= n_state;
                r_rd_idx     <= n_rd_idx;
                r_wr_idx     <= n_wr_idx;
                r_fill       <= n_fill;
                r_pos        <= n_pos;
                r_drop       <= n_drop;
                r_under      <= n_under;
                r_call_under <= n_call_under;
            end
            // advance render sequencer; hold when the queue is full
            if (w_issue) begin
                if (w_start_rend && (w_ch != 6'd1)) begin
                    r_rend  <= 1'b1;
                    r_rc    <= 6'd1;
                    r_have  <= w_have_cur;
                    r_rbase <= w_base_cur;
                end else if (r_rend) begin
                    if (r_rc + 6'd1 == w_ch) begin
                        r_rend <= 1'b0;
                    end
                    r_rc <= r_rc + 6'd1;
                end
            end
            r_p_valid <= w_issue;
            if (w_issue) begin
                r_p_res <= w_res;
            end
            // queue: drop head on take, append sanitized result
            unique case ({r_p_valid, w_out_take})
                2'b10: r_q_cnt <= r_q_cnt + 2'd1;
                2'b01: r_q_cnt <= r_q_cnt - 2'd1;
                default: ;
            endcase
            if (r_p_valid && w_slot0) begin
                r_q_res[0] <= r_p_res;
                r_q_smp[0] <= r_p_res.use_ring ? ppf_pkg::sanitize(w_rdata) : 32'd0;
            end else if (w_out_take) begin
                r_q_res[0] <= r_q_res[1];
                r_q_smp[0] <= r_q_smp[1];
            end
            if (r_p_valid && !w_slot0) begin
                r_q_res[1] <= r_p_res;
                r_q_smp[1] <= r_p_res.use_ring ? ppf_pkg::sanitize(w_rdata) : 32'd0;
            end
        end
    end

    assign o_out_valid       = (r_q_cnt != 2'd0);
    assign o_status_code     = r_q_res[0].status_code;
    assign o_sample_accepted = r_q_res[0].sample_accepted;
    assign o_out_sample      = r_q_smp[0];
    assign o_last_of_run     = r_q_res[0].last_of_run;
    assign o_play_state      = r_q_res[0].play_state;
    assign o_held_frames     = r_q_res[0].frames_held;
    assign o_underrun_total  = r_q_res[0].underrun_total;

    // queue never overfills
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_q_cnt != 2'd3)
        else $error("output queue overflow");
    // fill never exceeds ring size
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(ppf_pkg::RING_FRAMES))
        else $error("ring fill out of range");
    // no input taken during render sequence
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_rend |-> o_in_stall)
        else $error("input accepted mid render");

endmodule

// File: verif/tb.sv
// Self-checking testbench for the primed playback FIFO: random commands, predicted results.
`timescale 1ns / 1ps

class fifo_scoreboard;
    // Expected result words, oldest first, and the predicted block state.
    logic [1:0]  exp_status[$];
    logic        exp_acc[$];
    logic [31:0] exp_sample[$];
    logic        exp_last[$];
    logic [2:0]  exp_state[$];
    logic [10:0] exp_frames[$];
    logic [31:0] exp_under[$];

    logic [31:0] ring[0:8191];
    int unsigned rd_idx, wr_idx, fill, ch_pos, under;
    logic [2:0]  eng;
    bit          dropping, call_short;
    int unsigned chan_reg, thresh_reg;
    int          errors;

    function void clear();
        rd_idx = 0; wr_idx = 0; fill = 0; ch_pos = 0; under = 0;
        dropping = 0; call_short = 0; chan_reg = 2; thresh_reg = 0;
        eng = ppf_pkg::ST_IDLE; errors = 0;
        reprime();
    endfunction

    function int unsigned frame_width();
        if (chan_reg == 0) return 1;
        if (chan_reg > ppf_pkg::CH_SLOTS) return ppf_pkg::CH_SLOTS;
        return chan_reg;
    endfunction

    function void reprime();
        if (eng == ppf_pkg::ST_IDLE || eng == ppf_pkg::ST_PRIMED)
            eng = (fill >= thresh_reg) ? ppf_pkg::ST_PRIMED : ppf_pkg::ST_IDLE;
    endfunction

    function logic [31:0] clean(logic [31:0] b);
        if (b[30:23] == 8'hFF) return 32'd0;
        if (b[30:0] > 31'h3F80_0000) return {b[31], 31'h3F80_0000};
        return b;
    endfunction

    function void push(logic [1:0] st, logic acc, logic [31:0] smp, logic last);
        exp_status.push_back(st); exp_acc.push_back(acc); exp_sample.push_back(smp);
        exp_last.push_back(last); exp_state.push_back(eng);
        exp_frames.push_back(fill[10:0]); exp_under.push_back(under);
    endfunction

    function void write_reg(logic idx, int unsigned val);
        if (idx == ppf_pkg::REG_CHANNELS) chan_reg = val & 6'h3F;
        else thresh_reg = val & 11'h7FF;
    endfunction

    // Note one accepted input word and queue the results it causes.
    function void note_input(logic [2:0] cmd, logic [31:0] smp, logic cs);
        int unsigned ch, base;
        logic [1:0] st;
        logic acc;
        bit have;
        ch = frame_width(); st = ppf_pkg::STS_OK; acc = 0; have = 0; base = 0;
        case (cmd)
            ppf_pkg::CMD_SUBMIT: begin
                if (eng == ppf_pkg::ST_FAULTED) begin
                    st = ppf_pkg::STS_INVALID;
                end else begin
                    if (ch_pos == 0) dropping = fill >= ppf_pkg::RING_FRAMES;
                    if (!dropping) begin
                        ring[(wr_idx % 1024) * 8 + ch_pos % 8] = smp;
                        acc = 1;
                    end
                    if (ch_pos + 1 >= ch) begin
                        if (!dropping) begin
                            wr_idx = (wr_idx + 1) % 1024;
                            fill++;
                        end
                        ch_pos = 0; dropping = 0;
                    end else begin
                        ch_pos++;
                    end
                    reprime();
                end
            end
            ppf_pkg::CMD_RENDER: begin
                if (cs) call_short = 0;
                if (eng == ppf_pkg::ST_RUNNING) begin
                    if (fill > 0) begin
                        have = 1; base = rd_idx * 8;
                        rd_idx = (rd_idx + 1) % 1024; fill--;
                    end else if (!call_short) begin
                        call_short = 1;
                        if (under != 32'hFFFF_FFFF) under++;
                    end
                end
                for (int c = 0; c < ch; c++)
                    push(ppf_pkg::STS_OK, 0, have ? clean(ring[base + c]) : 32'd0,
                         c + 1 == ch);
                return;
            end
            ppf_pkg::CMD_START: begin
                if (eng == ppf_pkg::ST_PAUSED || eng == ppf_pkg::ST_PRIMED)
                    eng = ppf_pkg::ST_RUNNING;
                else if (eng != ppf_pkg::ST_RUNNING) st = ppf_pkg::STS_NOT_READY;
            end
            ppf_pkg::CMD_PAUSE: begin
                if (eng == ppf_pkg::ST_RUNNING) eng = ppf_pkg::ST_PAUSED;
                else if (eng != ppf_pkg::ST_PAUSED) st = ppf_pkg::STS_INVALID;
            end
            ppf_pkg::CMD_STOP: begin
                rd_idx = 0; wr_idx = 0; fill = 0; ch_pos = 0; dropping = 0;
                under = 0; call_short = 0; eng = ppf_pkg::ST_IDLE;
                reprime();
            end
            ppf_pkg::CMD_FAULT: eng = ppf_pkg::ST_FAULTED;
            default: st = ppf_pkg::STS_INVALID;
        endcase
        push(st, acc, 32'd0, 1);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Compare one accepted result word with the oldest expectation.
    task check_result(logic [1:0] st, logic acc, logic [31:0] smp, logic last,
                      logic [2:0] ps, logic [10:0] fr, logic [31:0] un);
        if (exp_status.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
        end
        if (st !== exp_status[0]) report("status_code", st, exp_status[0]);
        if (acc !== exp_acc[0]) report("sample_accepted", acc, exp_acc[0]);
        if (smp !== exp_sample[0]) report("out_sample", smp, exp_sample[0]);
        if (last !== exp_last[0]) report("last_of_run", last, exp_last[0]);
        if (ps !== exp_state[0]) report("play_state", ps, exp_state[0]);
        if (fr !== exp_frames[0]) report("held_frames", fr, exp_frames[0]);
        if (un !== exp_under[0]) report("underrun_total", un, exp_under[0]);
        void'(exp_status.pop_front()); void'(exp_acc.pop_front());
        void'(exp_sample.pop_front()); void'(exp_last.pop_front());
        void'(exp_state.pop_front()); void'(exp_frames.pop_front());
        void'(exp_under.pop_front());
    endtask
endclass

module tb;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [0:0]  i_cfg_index = 0;
    logic [10:0] i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [2:0]  i_cmd = 0;
    logic [31:0] i_sample_bits = 0;
    logic        i_call_start = 0;
    logic        o_out_valid;
    logic        i_out_stall = 1;
    logic [1:0]  o_status_code;
    logic        o_sample_accepted;
    logic [31:0] o_out_sample;
    logic        o_last_of_run;
    logic [2:0]  o_play_state;
    logic [10:0] o_held_frames;
    logic [31:0] o_underrun_total;

    fifo_scoreboard sb;
    bit stim_done = 0;
    int hold_off = 0;   // long receiver hold-off, in cycles, counted below

    primed_playback_fifo dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Receiver: check every accepted result word and stall at random after each.
    initial begin
        int wait_left;
        sb = new();
        sb.clear();
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result(o_status_code, o_sample_accepted, o_out_sample,
                                o_last_of_run, o_play_state, o_held_frames,
                                o_underrun_total);
                wait_left = $urandom_range(0, 9);
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_stall <= 1;
            end else if (wait_left > 0) begin
                wait_left--;
                i_out_stall <= 1;
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    // Offer one input word and hold it until the block takes it.
    task automatic send(logic [2:0] cmd, logic [31:0] smp, logic cs, int gap);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1;
        i_cmd         <= cmd;
        i_sample_bits <= smp;
        i_call_start  <= cs;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(cmd, smp, cs);
    endtask

    // Pick a random gap between words, or none when busy, giving idle-free stretches.
    function automatic int pick_gap(bit busy);
        return busy ? 0 : $urandom_range(0, 9);
    endfunction

    // Wait until every expected word has come, then let the tail drain.
    task automatic drain();
        i_in_valid <= 0;
        while (sb.exp_status.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] val);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7F80_0000 | $urandom_range(0, 1) << 31 | $urandom_range(0, 3);
            1: return {$urandom_range(0, 1) == 1, 31'h3F80_0000};
            2: return $urandom() & 32'hBF7F_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Submit whole frames of random content.
    task automatic submit_frames(int frames, int width, bit busy);
        for (int f = 0; f < frames; f++)
            for (int c = 0; c < width; c++)
                send(ppf_pkg::CMD_SUBMIT, rand_sample(), 0, pick_gap(busy));
    endtask

    initial begin
        int n, width, k;
        bit busy;
        logic [2:0] cmd;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: field extremes, every command, each special case.
        send(ppf_pkg::CMD_SUBMIT, 32'h7FC0_0000, 0, 0);   // NaN
        send(ppf_pkg::CMD_SUBMIT, 32'hFF80_0000, 0, 0);   // -inf
        send(ppf_pkg::CMD_SUBMIT, 32'hC000_0000, 0, 1);   // -2 clamps
        send(ppf_pkg::CMD_SUBMIT, 32'h8000_0000, 0, 0);   // -0 passes
        send(ppf_pkg::CMD_RENDER, 32'hFFFF_FFFF, 1, 0);   // primed, not running: zeros
        send(ppf_pkg::CMD_PAUSE, 0, 0, 0);                // invalid from primed
        send(ppf_pkg::CMD_START, 0, 0, 2);
        send(ppf_pkg::CMD_START, 0, 0, 0);                // already running
        send(ppf_pkg::CMD_RENDER, 0, 1, 0);
        send(ppf_pkg::CMD_RENDER, 0, 0, 0);
        send(ppf_pkg::CMD_RENDER, 0, 1, 0);               // underrun
        send(ppf_pkg::CMD_RENDER, 0, 0, 0);               // same callback, not counted
        send(ppf_pkg::CMD_PAUSE, 0, 0, 0);
        send(ppf_pkg::CMD_PAUSE, 0, 0, 0);
        send(3'd6, 32'hFFFF_FFFF, 1, 0);
        send(3'd7, 0, 0, 0);
        send(ppf_pkg::CMD_FAULT, 0, 0, 0);
        send(ppf_pkg::CMD_SUBMIT, 32'h3F80_0001, 0, 0);   // refused when faulted
        send(ppf_pkg::CMD_START, 0, 0, 0);                // not ready
        send(ppf_pkg::CMD_STOP, 0, 0, 0);
        drain();

        // Random phases over several register settings, the extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(ppf_pkg::REG_CHANNELS, 1);
                    write_reg(ppf_pkg::REG_THRESHOLD, 2);
                end
                1: begin
                    write_reg(ppf_pkg::REG_CHANNELS, 8);
                    write_reg(ppf_pkg::REG_THRESHOLD, 0);
                end
                2: begin
                    write_reg(ppf_pkg::REG_CHANNELS, 0);
                    write_reg(ppf_pkg::REG_THRESHOLD, 1024);
                end
                3: begin
                    write_reg(ppf_pkg::REG_CHANNELS, 63);
                    write_reg(ppf_pkg::REG_THRESHOLD, 2047);
                end
                4: begin
                    write_reg(ppf_pkg::REG_CHANNELS, 3);
                    write_reg(ppf_pkg::REG_THRESHOLD, 1);
                end
                default: begin
                    write_reg(ppf_pkg::REG_CHANNELS, $urandom_range(0, 63));
                    write_reg(ppf_pkg::REG_THRESHOLD, $urandom_range(0, 4));
                end
            endcase
            width = sb.frame_width();
            send(ppf_pkg::CMD_STOP, 0, 0, 0);
            // Long receiver hold-off while the sender keeps offering words.
            if (ph == 1) hold_off = 60;
            n = 0;
            while (n < 12) begin
                busy = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        k = $urandom_range(1, 3);
                        submit_frames(k, width, busy);
                        n += k * width;
                    end
                    3, 4, 5: begin
                        send(ppf_pkg::CMD_RENDER, 0, $urandom_range(0, 1), pick_gap(busy));
                        n++;
                    end
                    6: begin send(ppf_pkg::CMD_START, $urandom(), 0, pick_gap(busy)); n++; end
                    7: begin send(ppf_pkg::CMD_PAUSE, 0, 0, pick_gap(busy)); n++; end
                    8: begin
                        cmd = $urandom_range(0, 7);
                        // Stop and junk rarely, fault more rarely.
                        if (cmd == ppf_pkg::CMD_FAULT && $urandom_range(0, 3) != 0)
                            cmd = ppf_pkg::CMD_START;
                        send(cmd, $urandom(), $urandom_range(0, 1), pick_gap(busy));
                        n++;
                        if (cmd == ppf_pkg::CMD_FAULT) begin
                            send(ppf_pkg::CMD_STOP, 0, 0, 0);
                            n++;
                        end
                    end
                    default: begin
                        // Partial frame: random number of samples.
                        k = $urandom_range(1, width);
                        for (int j = 0; j < k; j++)
                            send(ppf_pkg::CMD_SUBMIT, rand_sample(), 0, pick_gap(busy));
                        n += k;
                    end
                endcase
            end
            drain();
        end
        stim_done = 1;
    end

    // End of run: verdict once the stimulus has drained.
    initial begin
        wait (stim_done);
        if (sb.errors == 0 && sb.exp_status.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #4ms;
        $display("Verification failed");
        $finish;
    end
endmodule

// File: files.f
rtl/ppf_pkg.sv
rtl/ppf_ring.sv
rtl/primed_playback_fifo.sv
verif/tb.sv
